### rtl/core/plucked_string_synth_assert.svh
// assertion macros, compiled out for synthesis
`ifndef PLUCKED_STRING_SYNTH_ASSERT_SVH
`define PLUCKED_STRING_SYNTH_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define PSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a property in the next cycle
`define PSS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define PSS_ASSERT(lbl, prop, msg)
`define PSS_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

### rtl/core/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 12;
  localparam int NOISE_W  = 13;
  localparam int LEVEL_W  = 11;
  localparam int LEN_W    = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd200;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_PLUCK = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  // two guard bits for sums and differences of samples
  typedef logic signed [SAMPLE_W+1:0] wide_t;

  localparam wide_t SAT_HI = wide_t'(8388607);
  localparam wide_t SAT_LO = wide_t'(-8388608);

  // one queued request, classified by the front end
  typedef struct packed {
    logic                      pluck;
    logic                      add_noise;
    logic signed [NOISE_W-1:0] noise;
    logic [LEVEL_W-1:0]        level;
  } op_t;

  function automatic sample_t sat_sample(input wide_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = sample_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = sample_t'(SAT_LO);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

### rtl/core/pss_front.sv
`timescale 1ns / 1ps
`include "plucked_string_synth_assert.svh"

module pss_front import pss_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      delay_length_write,
  input  logic [LEN_W-1:0]          delay_length,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic                      cmd,
  input  logic signed [NOISE_W-1:0] noise_sample,
  input  logic [LEVEL_W-1:0]        pluck_level,
  output logic                      push,
  output op_t                       push_op,
  output logic [$clog2(DELAY_DEPTH)-1:0] push_addr,
  input  logic                      full
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = $clog2(DELAY_DEPTH + 1);
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

  logic [LEN_W-1:0] delay_len;
  logic [PW-1:0]    position;
  logic             excite;

  logic [CW-1:0] len_ext;
  logic [CW-1:0] eff_len;
  logic          wrap;
  logic [AW-1:0] addr;
  logic          accept;

  assign cmd_stall = full;
  assign accept    = cmd_valid && !full;
  assign push      = accept;

  // zero length acts as one, long lengths clamp to the store depth
  always_comb begin
    len_ext = CW'(delay_len);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > DEPTH_C) begin
      eff_len = DEPTH_C;
    end else begin
      eff_len = len_ext;
    end
    wrap = CW'(position) >= eff_len;
    addr = wrap ? '0 : position[AW-1:0];
  end

  always_comb begin
    push_op.pluck     = (cmd == CMD_PLUCK);
    push_op.add_noise = excite && !wrap;
    push_op.noise     = noise_sample;
    push_op.level     = pluck_level;
    push_addr         = addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len <= LEN_RESET;
      position  <= '0;
      excite    <= 1'b1;
    end else begin
      if (delay_length_write) begin
        delay_len <= delay_length;
      end
      if (accept) begin
        if (cmd == CMD_PLUCK) begin
          excite <= 1'b0;
        end else begin
          position <= PW'(addr) + PW'(1);
          if (wrap) begin
            excite <= 1'b0;
          end
        end
      end
    end
  end

  `PSS_ASSERT_NEXT(a_pluck_ends_excite, accept && cmd == CMD_PLUCK, !excite, "pluck left excitation on")
  `PSS_ASSERT_NEXT(a_excite_stays_off, !excite, !excite, "excitation came back without reset")

endmodule

### rtl/core/pss_queue.sv
`timescale 1ns / 1ps
`include "plucked_string_synth_assert.svh"

module pss_queue import pss_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  op_t           push_op,
  input  logic [AW-1:0] push_addr,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output op_t           head_op,
  output logic [AW-1:0] head_addr
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t           ops   [DEPTH];
  logic [AW-1:0] addrs [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = ops[rd_ptr];
  assign head_addr  = addrs[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ops[wr_ptr]   <= push_op;
      addrs[wr_ptr] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `PSS_ASSERT(a_no_pop_empty, !pop || head_valid, "pop from empty queue")
  `PSS_ASSERT(a_no_push_full, !push || !full, "push into full queue")

endmodule

### rtl/core/pss_back.sv
`timescale 1ns / 1ps
`include "plucked_string_synth_assert.svh"

module pss_back import pss_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  op_t                            head_op,
  input  logic [$clog2(DELAY_DEPTH)-1:0] head_addr,
  output logic                           pop,
  output logic                           sample_valid,
  input  logic                           sample_stall,
  output logic signed [SAMPLE_W-1:0]     sample_out
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = $clog2(DELAY_DEPTH + 1);

  sample_t mem [DELAY_DEPTH];

  // execute stage
  logic          e_valid;
  op_t           e_op;
  logic [AW-1:0] e_addr;
  sample_t       rd_data;
  logic          rd_known;
  logic          fwd;

  sample_t       filter;
  logic [PW-1:0] fill;

  logic    advance;
  logic    complete;
  sample_t entry_raw;
  sample_t entry;
  wide_t   diff;
  wide_t   half;
  sample_t tick_val;
  sample_t pluck_val;
  sample_t result;

  assign advance  = !sample_valid || !sample_stall;
  assign pop      = advance && head_valid;
  assign complete = advance && e_valid;

  always_comb begin
    // entries past the fill mark were never written and read as zero
    if (fwd) begin
      entry_raw = filter;
    end else if (rd_known) begin
      entry_raw = rd_data;
    end else begin
      entry_raw = '0;
    end
    if (e_op.add_noise) begin
      entry = sat_sample(wide_t'(entry_raw) + wide_t'($signed(e_op.noise)));
    end else begin
      entry = entry_raw;
    end
    diff      = wide_t'(entry) - wide_t'(filter);
    half      = diff >>> 1;
    tick_val  = sat_sample(wide_t'(filter) + half);
    pluck_val = sample_t'({1'b0, e_op.level, {FRAC_W{1'b0}}});
    result    = e_op.pluck ? pluck_val : tick_val;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data  <= mem[head_addr];
      rd_known <= PW'(head_addr) < fill;
      // previous request writes the same entry at this edge
      fwd      <= e_valid && !e_op.pluck && (e_addr == head_addr);
      e_op     <= head_op;
      e_addr   <= head_addr;
    end
    if (complete && !e_op.pluck) begin
      mem[e_addr] <= result;
    end
    if (complete) begin
      sample_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid      <= 1'b0;
      sample_valid <= 1'b0;
      filter       <= '0;
      fill         <= '0;
    end else begin
      if (advance) begin
        e_valid      <= head_valid;
        sample_valid <= e_valid;
      end
      if (complete) begin
        filter <= result;
      end
      if (complete && !e_op.pluck && (PW'(e_addr) + PW'(1) > fill)) begin
        fill <= PW'(e_addr) + PW'(1);
      end
    end
  end

  `PSS_ASSERT_NEXT(a_done_shows, complete, sample_valid, "finished request not presented")
  `PSS_ASSERT(a_fill_bound, fill <= PW'(DELAY_DEPTH), "fill mark beyond store depth")

endmodule

### rtl/core/plucked_string_synth.sv
`timescale 1ns / 1ps
// channel       | direction | handshake                 | payload
// --------------+-----------+---------------------------+-------------------------------------
// command       | in        | cmd_valid / cmd_stall     | cmd, noise_sample, pluck_level
// sample        | out       | sample_valid / sample_stall | sample_out
// configuration | in        | delay_length_write        | delay_length
//
// one request per cycle unless output stalls; each passes queue, execute stage, output reg
// the one-pole update (noise add, halving, saturate) is combinational in the execute stage
// at most one delay-store read and one write per cycle; a same-entry read is forwarded
// reset (rst) is synchronous; never-written entries read zero via a fill mark
// output stall freezes the back end; the two-entry queue raises cmd_stall when full

module plucked_string_synth import pss_pkg::*; #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  // delay length register
  input  logic                       delay_length_write,
  input  logic [LEN_W-1:0]           delay_length,
  // command request
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic                       cmd,
  input  logic signed [NOISE_W-1:0]  noise_sample,
  input  logic [LEVEL_W-1:0]         pluck_level,
  // audio sample request
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int AW = $clog2(DELAY_DEPTH);

  // front end to queue
  logic          push;
  op_t           push_op;
  logic [AW-1:0] push_addr;
  logic          full;

  // queue to back end
  logic          pop;
  logic          head_valid;
  op_t           head_op;
  logic [AW-1:0] head_addr;

  // front end: holds position, excitation and length, picks the entry for each tick
  pss_front #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .delay_length_write(delay_length_write),
    .delay_length      (delay_length),
    .cmd_valid         (cmd_valid),
    .cmd_stall         (cmd_stall),
    .cmd               (cmd),
    .noise_sample      (noise_sample),
    .pluck_level       (pluck_level),
    .push              (push),
    .push_op           (push_op),
    .push_addr         (push_addr),
    .full              (full)
  );

  // short queue decouples command acceptance from output stalls
  pss_queue #(
    .AW(AW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .push_addr (push_addr),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op),
    .head_addr (head_addr)
  );

  // back end: delay store, lowpass filter and output register
  pss_back #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_op     (head_op),
    .head_addr   (head_addr),
    .pop         (pop),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_out  (sample_out)
  );

endmodule
